/* rtl/e2e_crc32_counter_protect_check_assert.svh */
// Assertion macros shared by the e2e CRC guard RTL.
// Pure text; no dependencies. Each macro expands to one labeled concurrent assertion.
`ifndef E2E_CRC32_COUNTER_PROTECT_CHECK_ASSERT_SVH
`define E2E_CRC32_COUNTER_PROTECT_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define E2ECRC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("e2ecrc: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define E2ECRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("e2ecrc: next-cycle check failed");

`endif

/* rtl/e2ecrc_pkg.sv */
// Package for the e2e CRC-32 / sequence counter guard: codes, types, CRC functions.
// No dependencies; used by e2ecrc_guard and the top level.
package e2ecrc_pkg;

    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;

    localparam int          COUNTER_LIMIT_DEFAULT = 255;
    localparam logic [7:0]  MAX_DELTA_RESET       = 8'd1;

    // config port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_DATA_ID   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DELTA = 1'd1;

    // frame layout of a check message (byte positions)
    localparam logic [2:0] POS_COUNTER = 3'd4;  // after 4 CRC bytes
    localparam logic [2:0] POS_PAYLOAD = 3'd6;  // after counter and id byte
    localparam logic [2:0] BYTE_SAT    = 3'd7;  // byte count saturation / min frame

    typedef enum logic [1:0] {
        OP_PROTECT   = 2'd0,
        OP_FORWARD   = 2'd1,
        OP_CHECK     = 2'd2,
        OP_CHECK_ALT = 2'd3   // handled as check
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_WRONG_CRC = 3'd2,
        ST_REPEATED  = 3'd3,
        ST_WRONG_SEQ = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] crc_word;
        logic [7:0]  counter_value;
        logic [7:0]  data_id_low;
    } result_t;

    // One byte of reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

    // CRC state after the two data-id bytes (high byte first).
    function automatic logic [31:0] crc_id_seed(input logic [15:0] id);
        return crc_byte(crc_byte(CRC_ALL_ONES, id[15:8]), id[7:0]);
    endfunction

    localparam logic [31:0] CRC_SEED_RESET = crc_id_seed(16'h0000);

endpackage

/* rtl/e2e_crc32_counter_protect_check.sv */
// Top level of the e2e CRC-32 / sequence counter guard: stream ports, config, staging.
// Depends on e2ecrc_pkg, e2ecrc_guard and e2e_crc32_counter_protect_check_assert.svh.
//
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------------
//  s_*      | in  | one message byte per transaction; tlast closes the message
//  m_*      | out | one result per message: status, CRC, counter, id byte
//  cfg_*    | in  | register writes: 0 data_id, 1 max_delta_counter
//
// One byte per cycle sustained while no closing byte waits on a stalled result. A
// transaction is registered, then processed by the guard's single-byte CRC step (two
// byte steps on the first byte of a non-check message) into the result register,
// which raises m_tvalid. The input register keeps taking bytes while a result waits;
// only a closing byte behind a stalled result holds s_tready low.
// aresetn is synchronous; it clears counters, CRC state and both valid flags.
// The data-id CRC prefix is computed once per data_id write and kept in a register.
module e2e_crc32_counter_protect_check #(
    parameter int COUNTER_LIMIT = e2ecrc_pkg::COUNTER_LIMIT_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] data_byte
    input  logic [2:0]                          s_tuser,   // [1:0] op, [2] has_byte
    input  logic                                s_tlast,   // last
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // [2:0] status, [34:3] crc_word,
                                                           // [42:35] counter_value,
                                                           // [50:43] data_id_low, rest 0
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [e2ecrc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [e2ecrc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // config registers
    logic [31:0] seed_id_reg;
    logic [7:0]  id_low_reg;
    logic [7:0]  max_delta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_id_reg   <= e2ecrc_pkg::CRC_SEED_RESET;
            id_low_reg    <= 8'h0;
            max_delta_reg <= e2ecrc_pkg::MAX_DELTA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                e2ecrc_pkg::REG_DATA_ID: begin
                    seed_id_reg <= e2ecrc_pkg::crc_id_seed(cfg_wdata);
                    id_low_reg  <= cfg_wdata[7:0];
                end
                e2ecrc_pkg::REG_MAX_DELTA: begin
                    max_delta_reg <= cfg_wdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    logic                in_valid_reg;
    e2ecrc_pkg::item_t   in_item_reg;
    logic                advance;

    // a non-closing byte never needs the result register
    assign advance  = in_valid_reg && (!in_item_reg.last || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op        <= e2ecrc_pkg::op_t'(s_tuser[1:0]);
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.has_byte  <= s_tuser[2];
            in_item_reg.last      <= s_tlast;
        end
    end

    // message guard
    e2ecrc_pkg::result_t guard_result;

    e2ecrc_guard #(
        .COUNTER_LIMIT (COUNTER_LIMIT)
    ) u_guard (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_adv  (advance),
        .item      (in_item_reg),
        .seed_id   (seed_id_reg),
        .max_delta (max_delta_reg),
        .id_low    (id_low_reg),
        .result    (guard_result)
    );

    // result register
    logic                out_valid_reg;
    e2ecrc_pkg::result_t out_result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last) begin
            out_result_reg <= guard_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0_0000,
                       out_result_reg.data_id_low,
                       out_result_reg.counter_value,
                       out_result_reg.crc_word,
                       out_result_reg.status};

`include "e2e_crc32_counter_protect_check_assert.svh"

    // a closing transaction always lands in the result register
    `E2ECRC_ASSERT_NEXT(a_close_to_out, aclk, aresetn, advance && in_item_reg.last, out_valid_reg)
    // a closing byte never overwrites a result still waiting
    `E2ECRC_ASSERT_SAME(a_no_overwrite, aclk, aresetn, out_valid_reg && !m_tready && in_valid_reg && in_item_reg.last, !advance)
    // a held input transaction stays intact
    `E2ECRC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg))

endmodule

/* rtl/e2ecrc_guard.sv */
// Message state and per-byte logic of the e2e guard: CRC, counters, header capture.
// Depends on e2ecrc_pkg and e2e_crc32_counter_protect_check_assert.svh.
module e2ecrc_guard #(
    parameter int COUNTER_LIMIT = e2ecrc_pkg::COUNTER_LIMIT_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_adv,    // item consumed this cycle
    input  e2ecrc_pkg::item_t    item,
    input  logic [31:0]          seed_id,     // CRC after data-id bytes
    input  logic [7:0]           max_delta,
    input  logic [7:0]           id_low,
    output e2ecrc_pkg::result_t  result       // valid when item_adv && item.last
);

    localparam logic [7:0] LIMIT_8  = 8'(COUNTER_LIMIT);
    localparam logic [9:0] WRAP_ADD = 10'(COUNTER_LIMIT + 1);

    logic [7:0]          pc_reg, pc_next;
    logic [7:0]          cc_reg, cc_next;
    logic [31:0]         crc_reg, crc_next;
    logic [2:0]          bc_reg, bc_next;
    logic [31:0]         rcrc_reg, rcrc_next;
    logic [7:0]          rcnt_reg, rcnt_next;
    e2ecrc_pkg::op_t     kind_reg, kind_next;

    logic        is_check;
    logic [7:0]  next_pc;
    logic [7:0]  seed_cnt;
    logic [31:0] crc_pre, crc_upd, crc_cur, crc_fin;
    logic        crc_step;
    logic [9:0]  delta;
    logic        seq_bad;

    always_comb begin
        kind_next = (bc_reg == 3'd0) ? item.op : kind_reg;
        is_check  = kind_next inside {e2ecrc_pkg::OP_CHECK, e2ecrc_pkg::OP_CHECK_ALT};
        next_pc   = (pc_reg < LIMIT_8) ? pc_reg + 8'd1 : 8'd0;
        seed_cnt  = (kind_next == e2ecrc_pkg::OP_PROTECT) ? next_pc : cc_reg;

        // one shared byte update; its base depends on position and kind
        if (!is_check && bc_reg == 3'd0) begin
            crc_pre = e2ecrc_pkg::crc_byte(seed_id, seed_cnt);
        end else if (is_check && bc_reg == e2ecrc_pkg::POS_COUNTER) begin
            crc_pre = seed_id;
        end else begin
            crc_pre = crc_reg;
        end
        crc_upd  = e2ecrc_pkg::crc_byte(crc_pre, item.data_byte);
        crc_step = item.has_byte && (!is_check || bc_reg == e2ecrc_pkg::POS_COUNTER
                                    || bc_reg >= e2ecrc_pkg::POS_PAYLOAD);
        crc_cur  = crc_step ? crc_upd : crc_reg;
        crc_fin  = crc_cur ^ e2ecrc_pkg::CRC_ALL_ONES;

        rcrc_next = rcrc_reg;
        if (item.has_byte && is_check && bc_reg < e2ecrc_pkg::POS_COUNTER) begin
            case (bc_reg[1:0])
                2'd0:    rcrc_next[7:0]   = item.data_byte;
                2'd1:    rcrc_next[15:8]  = item.data_byte;
                2'd2:    rcrc_next[23:16] = item.data_byte;
                default: rcrc_next[31:24] = item.data_byte;
            endcase
        end
        rcnt_next = rcnt_reg;
        if (item.has_byte && is_check && bc_reg == e2ecrc_pkg::POS_COUNTER) begin
            rcnt_next = item.data_byte;
        end
        bc_next = (item.has_byte && bc_reg < e2ecrc_pkg::BYTE_SAT) ? bc_reg + 3'd1 : bc_reg;

        // wrapped counter advance; negative after wrap counts as too far
        delta = {2'b00, rcnt_next} - {2'b00, cc_reg};
        if (rcnt_next < cc_reg) begin
            delta = delta + WRAP_ADD;
        end
        seq_bad = delta[9] || (delta[8:0] > {1'b0, max_delta});

        pc_next  = pc_reg;
        cc_next  = cc_reg;
        crc_next = crc_cur;
        result.status        = e2ecrc_pkg::ST_OK;
        result.crc_word      = 32'h0;
        result.counter_value = 8'h0;
        result.data_id_low   = id_low;

        if (item.last) begin
            if (is_check) begin
                if (bc_next < e2ecrc_pkg::BYTE_SAT) begin
                    result.status = e2ecrc_pkg::ST_TOO_SHORT;
                end else begin
                    result.crc_word      = crc_fin;
                    result.counter_value = rcnt_next;
                    if (crc_fin != rcrc_next) begin
                        result.status = e2ecrc_pkg::ST_WRONG_CRC;
                    end else if (rcnt_next == cc_reg) begin
                        result.status = e2ecrc_pkg::ST_REPEATED;
                    end else begin
                        cc_next       = rcnt_next;
                        result.status = seq_bad ? e2ecrc_pkg::ST_WRONG_SEQ
                                                : e2ecrc_pkg::ST_OK;
                    end
                end
            end else if (bc_next == 3'd0) begin
                result.status = e2ecrc_pkg::ST_EMPTY;
            end else begin
                result.crc_word      = crc_fin;
                result.counter_value = seed_cnt;
                pc_next              = seed_cnt;
            end
            // message closes
            bc_next   = 3'd0;
            crc_next  = e2ecrc_pkg::CRC_ALL_ONES;
            rcrc_next = 32'h0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= 8'h0;
            cc_reg   <= 8'h0;
            crc_reg  <= e2ecrc_pkg::CRC_ALL_ONES;
            bc_reg   <= 3'd0;
            rcrc_reg <= 32'h0;
            rcnt_reg <= 8'h0;
            kind_reg <= e2ecrc_pkg::OP_PROTECT;
        end else if (item_adv) begin
            pc_reg   <= pc_next;
            cc_reg   <= cc_next;
            crc_reg  <= crc_next;
            bc_reg   <= bc_next;
            rcrc_reg <= rcrc_next;
            rcnt_reg <= rcnt_next;
            kind_reg <= kind_next;
        end
    end

`include "e2e_crc32_counter_protect_check_assert.svh"

    // every message boundary returns to the idle frame state
    `E2ECRC_ASSERT_NEXT(a_close_clears, aclk, aresetn, item_adv && item.last, bc_reg == 3'd0 && crc_reg == e2ecrc_pkg::CRC_ALL_ONES && rcrc_reg == 32'h0)
    // byte count only grows inside a message
    `E2ECRC_ASSERT_NEXT(a_bc_monotonic, aclk, aresetn, item_adv && !item.last, bc_reg >= $past(bc_reg))
    // check counter moves only when a check message closes
    `E2ECRC_ASSERT_NEXT(a_cc_hold, aclk, aresetn, !(item_adv && item.last && is_check), $stable(cc_reg))
    // too-short or empty messages report no CRC and no counter
    `E2ECRC_ASSERT_SAME(a_reject_zero, aclk, aresetn, item_adv && item.last && (result.status == e2ecrc_pkg::ST_EMPTY || result.status == e2ecrc_pkg::ST_TOO_SHORT), result.crc_word == 32'h0 && result.counter_value == 8'h0)

endmodule
